/* rtl/hsv2bgr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hsv2bgr_pkg;

    // Input and result field widths
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned TDATA_W = 24;

    // Hue geometry, in two-degree units
    localparam logic [CHAN_W-1:0] HUE_WRAP = 8'd180;
    localparam logic [4:0] HUE_PER_SECTOR = 5'd30;

    // Common denominator 255 * 30
    localparam int unsigned DENOM = 7650;
    localparam int unsigned COEF_W = 13;     // holds 0..7650
    localparam int unsigned PROD_W = 21;     // brightness * coefficient
    localparam int unsigned NUM_W = 22;      // 2 * product + DENOM

    // Rounded divide by 2 * DENOM as multiply by a ceiling reciprocal.
    // Exact for every numerator below 2^NUM_W.
    localparam int unsigned RECIP_SHIFT = 36;
    localparam int unsigned RECIP_W = 23;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(2 * DENOM) - 64'd1) / 64'(2 * DENOM);
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP_FULL);
    localparam int unsigned MUL_W = NUM_W + RECIP_W;

    localparam logic [COEF_W-1:0] DENOM_C = COEF_W'(DENOM);

    // Candidate select codes
    typedef enum logic [1:0] {
        CAND_V    = 2'd0,   // v
        CAND_VS   = 2'd1,   // v(1-s)
        CAND_VSF  = 2'd2,   // v(1-s*f)
        CAND_VSNF = 2'd3    // v(1-s(1-f))
    } cand_sel_t;

    // Output lanes
    localparam int unsigned LANE_BLUE = 0;
    localparam int unsigned LANE_GREEN = 1;
    localparam int unsigned LANE_RED = 2;
    localparam int unsigned NUM_LANES = 3;

    typedef struct packed {
        cand_sel_t red;
        cand_sel_t green;
        cand_sel_t blue;
    } pick_t;

    // Per sector candidate selection
    function automatic pick_t pick_for_sector(input logic [2:0] sector);
        pick_t p;
        unique case (sector)
            3'd0:    p = '{red: CAND_V,    green: CAND_VSNF, blue: CAND_VS};
            3'd1:    p = '{red: CAND_VSF,  green: CAND_V,    blue: CAND_VS};
            3'd2:    p = '{red: CAND_VS,   green: CAND_V,    blue: CAND_VSNF};
            3'd3:    p = '{red: CAND_VS,   green: CAND_VSF,  blue: CAND_V};
            3'd4:    p = '{red: CAND_VSNF, green: CAND_VS,   blue: CAND_V};
            3'd5:    p = '{red: CAND_V,    green: CAND_VS,   blue: CAND_VSF};
            default: p = '{red: CAND_V,    green: CAND_V,    blue: CAND_V};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* rtl/hsv_to_bgr_pixel.sv */
`timescale 1ns / 1ps
`default_nettype none

// HSV to BGR pixel converter. Takes one pixel per clock while s_tready is
// high and returns one blue/green/red beat per pixel. An accepted pixel
// moves through the four register stages in order (hue split, coefficient
// products, brightness multiply, reciprocal multiply), each with at most one
// multiply on its path; m_tvalid rises when its beat reaches the last one.
// Throughput is one beat a clock while the output does not stall.
// Hue is in two-degree units (180 or more wraps), saturation and value are
// bytes; each channel is rounded half away from zero. Each stage moves on
// whenever its successor can take its beat, so bubbles are squeezed out and
// a new pixel is accepted while a finished one still waits at the output.
module hsv_to_bgr_pixel
    import hsv2bgr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [TDATA_W-1:0]  s_tdata,   // hue, saturation, brightness
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata    // blue, green, red
);

    // ---------------------------------------------------------------
    // Stage advance chain: a stage loads when it is empty or its
    // successor loads in the same cycle.
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    assign v1_next = en1 ? s_tvalid : v1_reg;
    assign v2_next = en2 ? v1_reg   : v2_reg;
    assign v3_next = en3 ? v2_reg   : v3_reg;
    assign v4_next = en4 ? v3_reg   : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: wrap hue, split into sector and remainder
    // ---------------------------------------------------------------
    logic [CHAN_W-1:0] in_hue, in_sat, in_val;
    logic [CHAN_W-1:0] hue_wrapped;
    logic [CHAN_W-1:0] sector_base;
    logic [2:0]        sector_next;
    logic [4:0]        rem_next;

    assign in_hue = s_tdata[CHAN_W-1:0];
    assign in_sat = s_tdata[2*CHAN_W-1:CHAN_W];
    assign in_val = s_tdata[3*CHAN_W-1:2*CHAN_W];

    assign hue_wrapped = (in_hue >= HUE_WRAP) ? (in_hue - HUE_WRAP) : in_hue;

    always_comb begin
        priority if (hue_wrapped >= 8'd150) begin
            sector_next = 3'd5;
            sector_base = 8'd150;
        end else if (hue_wrapped >= 8'd120) begin
            sector_next = 3'd4;
            sector_base = 8'd120;
        end else if (hue_wrapped >= 8'd90) begin
            sector_next = 3'd3;
            sector_base = 8'd90;
        end else if (hue_wrapped >= 8'd60) begin
            sector_next = 3'd2;
            sector_base = 8'd60;
        end else if (hue_wrapped >= 8'd30) begin
            sector_next = 3'd1;
            sector_base = 8'd30;
        end else begin
            sector_next = 3'd0;
            sector_base = 8'd0;
        end
    end

    assign rem_next = 5'(hue_wrapped - sector_base);

    logic [2:0]        sector_reg;
    logic [4:0]        rem_reg;
    logic [CHAN_W-1:0] sat1_reg, val1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            sector_reg <= sector_next;
            rem_reg    <= rem_next;
            sat1_reg   <= in_sat;
            val1_reg   <= in_val;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: candidate coefficients over DENOM, picked per lane
    // ---------------------------------------------------------------
    logic [COEF_W-1:0] sat_x30, sat_xf, sat_xnf;
    logic [COEF_W-1:0] cand_coef [4];
    logic [COEF_W-1:0] coef_next [NUM_LANES];
    pick_t             pick;

    assign sat_x30 = COEF_W'(sat1_reg) * COEF_W'(HUE_PER_SECTOR);
    assign sat_xf  = COEF_W'(sat1_reg) * COEF_W'(rem_reg);
    assign sat_xnf = COEF_W'(sat1_reg) * COEF_W'(HUE_PER_SECTOR - rem_reg);

    assign cand_coef[CAND_V]    = DENOM_C;
    assign cand_coef[CAND_VS]   = DENOM_C - sat_x30;
    assign cand_coef[CAND_VSF]  = DENOM_C - sat_xf;
    assign cand_coef[CAND_VSNF] = DENOM_C - sat_xnf;

    assign pick = pick_for_sector(sector_reg);
    assign coef_next[LANE_BLUE]  = cand_coef[pick.blue];
    assign coef_next[LANE_GREEN] = cand_coef[pick.green];
    assign coef_next[LANE_RED]   = cand_coef[pick.red];

    logic [COEF_W-1:0] coef_reg [NUM_LANES];
    logic [CHAN_W-1:0] val2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            coef_reg <= coef_next;
            val2_reg <= val1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: scale by brightness, add half for rounding
    // ---------------------------------------------------------------
    logic [NUM_W-1:0] num_next [NUM_LANES];
    logic [PROD_W-1:0] prod [NUM_LANES];

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            prod[i]     = PROD_W'(val2_reg) * PROD_W'(coef_reg[i]);
            num_next[i] = {prod[i], 1'b0} + NUM_W'(DENOM);
        end
    end

    logic [NUM_W-1:0] num_reg [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (en3) begin
            num_reg <= num_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: divide by 2*DENOM through the reciprocal; output register
    // ---------------------------------------------------------------
    logic [MUL_W-1:0]  quot_full [NUM_LANES];
    logic [CHAN_W-1:0] chan_next [NUM_LANES];

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            quot_full[i] = MUL_W'(num_reg[i]) * MUL_W'(RECIP_K);
            chan_next[i] = quot_full[i][RECIP_SHIFT +: CHAN_W];
        end
    end

    logic [CHAN_W-1:0] chan_reg [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (en4) begin
            chan_reg <= chan_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {chan_reg[LANE_RED], chan_reg[LANE_GREEN], chan_reg[LANE_BLUE]};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (sector_reg <= 3'd5 && rem_reg < HUE_PER_SECTOR))
        else $error("hue split out of range");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready) |-> !s_tready)
        else $error("input taken into a full pipeline");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_tready)
        else $error("empty first stage refuses a beat");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && en4) |=> m_tvalid)
        else $error("beat lost between last two stages");

endmodule

`default_nettype wire
